FILE: src/radix2_fft_frame_unit_assert.svh
// Assertion macros for the radix-2 FFT frame unit.
`ifndef RADIX2_FFT_FRAME_UNIT_ASSERT_SVH
`define RADIX2_FFT_FRAME_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define R2F_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define R2F_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/r2fft_pkg.sv
// Package for the radix-2 FFT frame unit: sizes, state type and twiddle table.
package r2fft_pkg;
    localparam int MaxPoints  = 64;
    localparam int SampleBits = 16;
    localparam int TwBits     = 17;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD,
        ST_WAIT,
        ST_MUL,
        ST_WR,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    // Q2.15 cosine of k angle steps (the top level passes step = 2*pi/MAX_POINTS), +1.0 as 32768
    function automatic logic signed [TwBits-1:0] tw_cos(input int k, input real step);
        real v;
        v = $cos(step * k) * 32768.0;
        return TwBits'($rtoi(v >= 0.0 ? v + 0.5 : v - 0.5));
    endfunction

    // Q2.15 sine of k angle steps
    function automatic logic signed [TwBits-1:0] tw_sin(input int k, input real step);
        real v;
        v = $sin(step * k) * 32768.0;
        return TwBits'($rtoi(v >= 0.0 ? v + 0.5 : v - 0.5));
    endfunction
endpackage

FILE: src/r2fft_butterfly.sv
// Registered butterfly: complex twiddle product, rounding and sum/difference.
module r2fft_butterfly #(
    parameter int StoreBits = 23
) (
    input  logic                                 aclk,
    input  logic                                 load,
    input  logic signed [StoreBits-1:0]          ar,
    input  logic signed [StoreBits-1:0]          ai,
    input  logic signed [StoreBits-1:0]          br,
    input  logic signed [StoreBits-1:0]          bi,
    input  logic signed [r2fft_pkg::TwBits-1:0]  wc,
    input  logic signed [r2fft_pkg::TwBits-1:0]  ws,
    output logic signed [StoreBits-1:0]          xr,
    output logic signed [StoreBits-1:0]          xi,
    output logic signed [StoreBits-1:0]          yr,
    output logic signed [StoreBits-1:0]          yi
);
    localparam int PBits = StoreBits + r2fft_pkg::TwBits;
    logic signed [PBits-1:0] p_cb_reg, p_sb_reg, p_ci_reg, p_sr_reg;
    logic signed [StoreBits-1:0] ar_reg, ai_reg;
    logic signed [PBits:0] sr, si;
    logic signed [StoreBits-1:0] tr, ti;

    // Hold the four partial products
    always_ff @(posedge aclk) begin
        if (load) begin
            p_cb_reg <= PBits'(wc * br);
            p_sb_reg <= PBits'(ws * bi);
            p_ci_reg <= PBits'(wc * bi);
            p_sr_reg <= PBits'(ws * br);
            ar_reg   <= ar;
            ai_reg   <= ai;
        end
    end

    // Sum, round to nearest by 15 bits, wrap to store width
    always_comb begin
        sr = (PBits+1)'(p_cb_reg) + (PBits+1)'(p_sb_reg) + (PBits+1)'(1 <<< 14);
        si = (PBits+1)'(p_ci_reg) - (PBits+1)'(p_sr_reg) + (PBits+1)'(1 <<< 14);
        tr = sr[StoreBits+14:15];
        ti = si[StoreBits+14:15];
        xr = ar_reg + tr;
        xi = ai_reg + ti;
        yr = ar_reg - tr;
        yi = ai_reg - ti;
    end
endmodule

FILE: src/radix2_fft_frame_unit.sv
// Top level of the radix-2 decimation-in-time FFT frame unit.
// Samples are taken one per cycle, while s_tvalid is high, into a bit-reversed store
// until 2^points_log2 have arrived; the last sample starts the transform, which one
// butterfly unit runs in place, each butterfly in read, wait, multiply and write steps
// (both results written back through the store's two write ports), (N/2)*log2(N)
// butterflies; then N bins are read out in natural order, each read and then offered
// until m_tready takes it. No clearing pass follows reset.
`include "radix2_fft_frame_unit_assert.svh"
module radix2_fft_frame_unit #(
    parameter int MAX_POINTS  = r2fft_pkg::MaxPoints,
    parameter int SAMPLE_BITS = r2fft_pkg::SampleBits
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_re, sample_im
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bin_re, bin_im, bin_index
    output logic [((2*(SAMPLE_BITS+$clog2(MAX_POINTS)+1)+$clog2(MAX_POINTS)+7)/8)*8-1:0] m_tdata,
    output logic        m_tlast
);
    localparam int Lg    = $clog2(MAX_POINTS);
    localparam int SB    = SAMPLE_BITS + Lg + 1;
    localparam int OutW  = ((2*SB + Lg + 7) / 8) * 8;
    localparam int SW    = $clog2(Lg + 1);
    localparam int TwN   = (MAX_POINTS / 2 > 1) ? MAX_POINTS / 2 : 2;
    localparam real TwStep = 2.0 * 3.14159265358979323846 / MAX_POINTS;

    logic signed [SB-1:0] re_mem [MAX_POINTS];
    logic signed [SB-1:0] im_mem [MAX_POINTS];

    r2fft_pkg::state_t state_reg, state_next;
    logic [2:0]     plog_reg;
    logic [Lg-1:0]  cnt_reg, cnt_next;
    logic [SW-1:0]  stage_reg, stage_next;
    logic [Lg-1:0]  bf_reg, bf_next;
    logic [Lg-1:0]  used;
    logic [Lg:0]    npts;

    // Effective length, clamped to [1, Lg]
    always_comb begin
        logic [2:0] l;
        l = plog_reg;
        if (l == 3'd0) l = 3'd1;
        if (32'(l) > Lg) l = 3'(Lg);
        used = Lg'(l);
        npts = (Lg+1)'(1) << l;
    end

    // Bit-reversed write position within the used length
    logic [Lg-1:0] rev_pos;
    always_comb begin
        rev_pos = '0;
        for (int i = 0; i < Lg; i++)
            if (i < 32'(used)) rev_pos[32'(used)-1-i] = cnt_reg[i];
    end

    // Butterfly addressing: half = 2^(stage-1)
    logic [Lg-1:0] half, jj, addr_a, addr_b, tw_idx;
    always_comb begin
        half   = Lg'(1) << (stage_reg - SW'(1));
        jj     = bf_reg & (half - Lg'(1));
        addr_a = ((bf_reg & ~(half - Lg'(1))) << 1) | jj;
        addr_b = addr_a | half;
        tw_idx = jj << (SW'(Lg) - stage_reg);
    end

    // Twiddle table
    logic signed [r2fft_pkg::TwBits-1:0] wc_tab [TwN];
    logic signed [r2fft_pkg::TwBits-1:0] ws_tab [TwN];
    for (genvar k = 0; k < TwN; k++) begin : g_tw
        assign wc_tab[k] = r2fft_pkg::tw_cos(k, TwStep);
        assign ws_tab[k] = r2fft_pkg::tw_sin(k, TwStep);
    end
    logic signed [r2fft_pkg::TwBits-1:0] wc_reg, ws_reg;

    // Memory ports
    logic signed [SB-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [SB-1:0] xr, xi, yr, yi;
    logic [Lg-1:0] rd_a, rd_b;
    logic          wr_en;
    logic [Lg-1:0] wa, wb;
    logic signed [SB-1:0] wra, wia, wrb, wib;
    logic          wr_b;

    // Hold the bin address while it is read out and offered
    always_comb begin
        rd_a = (state_reg == r2fft_pkg::ST_EMIT_RD || state_reg == r2fft_pkg::ST_EMIT) ?
               cnt_reg : addr_a;
        rd_b = addr_b;
    end

    always_ff @(posedge aclk) begin
        ar_reg <= re_mem[rd_a];
        ai_reg <= im_mem[rd_a];
        br_reg <= re_mem[rd_b];
        bi_reg <= im_mem[rd_b];
        if (wr_en) begin
            re_mem[wa] <= wra;
            im_mem[wa] <= wia;
        end
        if (wr_b) begin
            re_mem[wb] <= wrb;
            im_mem[wb] <= wib;
        end
    end

    r2fft_butterfly #(.StoreBits(SB)) u_bfly (
        .aclk (aclk),
        .load (state_reg == r2fft_pkg::ST_WAIT),
        .ar (ar_reg), .ai (ai_reg), .br (br_reg), .bi (bi_reg),
        .wc (wc_reg), .ws (ws_reg),
        .xr (xr), .xi (xi), .yr (yr), .yi (yi)
    );

    logic load_acc;
    assign s_tready = (state_reg == r2fft_pkg::ST_LOAD);
    assign load_acc = s_tvalid && s_tready;

    // Next state and counters
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stage_next = stage_reg;
        bf_next    = bf_reg;
        case (state_reg)
            r2fft_pkg::ST_LOAD: begin
                if (load_acc) begin
                    if ((Lg+1)'(cnt_reg) + (Lg+1)'(1) == npts) begin
                        cnt_next   = '0;
                        stage_next = SW'(1);
                        bf_next    = '0;
                        state_next = r2fft_pkg::ST_RD;
                    end else begin
                        cnt_next = cnt_reg + Lg'(1);
                    end
                end
            end
            r2fft_pkg::ST_RD:   state_next = r2fft_pkg::ST_WAIT;
            r2fft_pkg::ST_WAIT: state_next = r2fft_pkg::ST_MUL;
            r2fft_pkg::ST_MUL:  state_next = r2fft_pkg::ST_WR;
            r2fft_pkg::ST_WR: begin
                if ((Lg+1)'(bf_reg) + (Lg+1)'(1) == (npts >> 1)) begin
                    bf_next = '0;
                    if (stage_reg == SW'(used)) begin
                        cnt_next   = '0;
                        state_next = r2fft_pkg::ST_EMIT_RD;
                    end else begin
                        stage_next = stage_reg + SW'(1);
                        state_next = r2fft_pkg::ST_RD;
                    end
                end else begin
                    bf_next    = bf_reg + Lg'(1);
                    state_next = r2fft_pkg::ST_RD;
                end
            end
            r2fft_pkg::ST_EMIT_RD: state_next = r2fft_pkg::ST_EMIT;
            r2fft_pkg::ST_EMIT: begin
                if (m_tready) begin
                    if ((Lg+1)'(cnt_reg) + (Lg+1)'(1) == npts) begin
                        cnt_next   = '0;
                        state_next = r2fft_pkg::ST_LOAD;
                    end else begin
                        cnt_next   = cnt_reg + Lg'(1);
                        state_next = r2fft_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: state_next = r2fft_pkg::ST_LOAD;
        endcase
        if (cfg_we) cnt_next = '0;
    end

    // Outputs and write ports
    always_comb begin
        wr_en = 1'b0;
        wr_b  = 1'b0;
        wa    = addr_a;
        wb    = addr_b;
        wra   = xr;
        wia   = xi;
        wrb   = yr;
        wib   = yi;
        m_tvalid = 1'b0;
        case (state_reg)
            r2fft_pkg::ST_LOAD: begin
                wr_en = load_acc;
                wa    = rev_pos;
                wra   = SB'($signed(s_tdata[SAMPLE_BITS-1:0]));
                wia   = SB'($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
            end
            r2fft_pkg::ST_WR: begin
                wr_en = 1'b1;
                wr_b  = 1'b1;
            end
            r2fft_pkg::ST_EMIT: m_tvalid = 1'b1;
            default: wr_en = 1'b0;
        endcase
    end

    assign m_tdata = OutW'({cnt_reg, ai_reg, ar_reg});
    assign m_tlast = ((Lg+1)'(cnt_reg) + (Lg+1)'(1) == npts);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= r2fft_pkg::ST_LOAD;
            plog_reg  <= 3'd6;
            cnt_reg   <= '0;
            stage_reg <= SW'(1);
            bf_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stage_reg <= stage_next;
            bf_reg    <= bf_next;
            if (cfg_we) plog_reg <= cfg_wdata;
        end
    end

    // Latch the twiddle for this butterfly
    always_ff @(posedge aclk) begin
        if (state_reg == r2fft_pkg::ST_RD) begin
            wc_reg <= wc_tab[tw_idx[(Lg > 1 ? Lg-2 : 0):0]];
            ws_reg <= ws_tab[tw_idx[(Lg > 1 ? Lg-2 : 0):0]];
        end
    end

    `R2F_ASSERT_IMPL(a_no_load_out, aclk, aresetn, m_tvalid, !s_tready, "input taken while emitting")
    `R2F_ASSERT_NEXT(a_last_back, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready, "no return to loading after last bin")
    `R2F_ASSERT_IMPL(a_wr_rd, aclk, aresetn, state_reg == r2fft_pkg::ST_WR, addr_a != addr_b, "butterfly ports collide")
endmodule
